// ----- sv/assert_macros.svh -----
// Assertion macros for the free-list slot allocator files.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Assertion failed in the slot allocator.");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Assertion failed in the slot allocator.");

`endif

// ----- sv/fsla_pkg.sv -----
// Package for the free-list slot allocator: default size, transaction kind codes,
// controller states and the command and status structs. Depends on nothing.
package fsla_pkg;

   localparam int SLOTS_DEFAULT = 1024;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   typedef enum logic [1:0] {
      ST_INIT,
      ST_IDLE,
      ST_POP
   } state_type;

   typedef struct packed {
      logic init_write;
      logic accept;
      logic push;
      logic pop_issue;
      logic pop_load;
   } cmd_type;

   typedef struct packed {
      logic init_last;
      logic head_ok;
      logic idx_ok;
      logic out_free;
   } status_type;

endpackage

// ----- sv/fsla_ctrl.sv -----
// Controller of the free-list slot allocator: link store initialisation sweep,
// request acceptance and the pop sequence. Depends on fsla_pkg.
module fsla_ctrl
   import fsla_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_kind,
   input  status_type status,
   output cmd_type    cmd,
   output logic       req_stall
);

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign accept = (state_ff == ST_IDLE) && req_valid && status.out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (status.init_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && (req_kind == KIND_ALLOC) && status.head_ok) begin
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_INIT: begin
            cmd.init_write = 1'b1;
         end
         ST_IDLE: begin
            req_stall     = !status.out_free;
            cmd.accept    = accept;
            cmd.push      = accept && (req_kind == KIND_FREE) && status.idx_ok;
            cmd.pop_issue = accept && (req_kind == KIND_ALLOC) && status.head_ok;
         end
         ST_POP: begin
            cmd.pop_load = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ----- sv/fsla_datapath.sv -----
// Datapath of the free-list slot allocator: link store memory, free-list head,
// initialisation counter and the response register. Depends on fsla_pkg.
module fsla_datapath
   import fsla_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT,
   localparam int IDX_W = $clog2(SLOTS),
   localparam int GNT_W = $clog2(SLOTS + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output status_type       status,
   input  logic             req_kind,
   input  logic [IDX_W-1:0] req_slot_index,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [GNT_W-1:0] rsp_granted_index,
   output logic             rsp_bad_index
);

   localparam logic [GNT_W-1:0] END_MARK = GNT_W'(SLOTS);

   logic [GNT_W-1:0] link_store_ff [SLOTS];
   logic [GNT_W-1:0] rd_data_ff;
   logic [GNT_W-1:0] head_ff;
   logic [GNT_W-1:0] head_in;
   logic [IDX_W-1:0] init_cnt_ff;
   logic [IDX_W-1:0] init_cnt_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [GNT_W-1:0] granted_ff;
   logic             bad_ff;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [GNT_W-1:0] wr_data;
   logic [GNT_W-1:0] granted_calc;
   logic             bad_calc;

   assign status.init_last = (init_cnt_ff == IDX_W'(SLOTS - 1));
   assign status.head_ok   = (head_ff < END_MARK);
   assign status.idx_ok    = (GNT_W'(req_slot_index) < END_MARK);
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign wr_en   = cmd.init_write || cmd.push;
   assign wr_addr = cmd.init_write ? init_cnt_ff : req_slot_index;
   assign wr_data = cmd.init_write ? (GNT_W'(init_cnt_ff) + GNT_W'(1)) : head_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_store_ff[wr_addr] <= wr_data;
      end
      if (cmd.pop_issue) begin
         rd_data_ff <= link_store_ff[head_ff[IDX_W-1:0]];
      end
   end

   always_comb begin
      priority if (cmd.push) begin
         head_in = GNT_W'(req_slot_index);
      end else if (cmd.pop_load) begin
         head_in = rd_data_ff;
      end else begin
         head_in = head_ff;
      end
   end

   assign init_cnt_in = cmd.init_write ? (init_cnt_ff + IDX_W'(1)) : init_cnt_ff;

   assign granted_calc = ((req_kind == KIND_ALLOC) && status.head_ok) ? head_ff : END_MARK;
   assign bad_calc     = (req_kind == KIND_FREE) && !status.idx_ok;

   always_comb begin
      priority if (cmd.accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         init_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         init_cnt_ff  <= init_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         granted_ff <= granted_calc;
         bad_ff     <= bad_calc;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted_index = granted_ff;
   assign rsp_bad_index     = bad_ff;

endmodule

// ----- sv/free_list_slot_allocator_unit.sv -----
// Top level of the free-list slot allocator: joins controller and datapath.
// Depends on fsla_pkg, fsla_ctrl, fsla_datapath and assert_macros.svh.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_stall   req_kind, req_slot_index
//   rsp      out        rsp_valid/rsp_stall   rsp_granted_index, rsp_bad_index
//
// A free, an out-of-range free and an allocate on an empty list leave the controller idle.
// An allocate that pops passes through ST_POP, where requests are stalled while the new
// head is loaded from the registered read of the link store RAM.
// After reset a sweep initialises the SLOTS link store entries (1024 by default) in turn;
// requests are stalled until that sweep ends.
// Responses sit in an output register; a request is taken while it is empty or drained.
`include "assert_macros.svh"

module free_list_slot_allocator_unit
   import fsla_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT,
   localparam int IDX_W = $clog2(SLOTS),
   localparam int GNT_W = $clog2(SLOTS + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_kind,
   input  logic [IDX_W-1:0] req_slot_index,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [GNT_W-1:0] rsp_granted_index,
   output logic             rsp_bad_index
);

   cmd_type    cmd;
   status_type status;

   fsla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   fsla_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_kind          (req_kind),
      .req_slot_index    (req_slot_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_granted_index (rsp_granted_index),
      .rsp_bad_index     (rsp_bad_index)
   );

   `ASSERT_SAME(a_accept_needs_room, clock, reset, req_valid && !req_stall, !rsp_valid || !rsp_stall)
   `ASSERT_NEXT(a_pop_loads_head, clock, reset, cmd.pop_issue, cmd.pop_load && req_stall)
   `ASSERT_SAME(a_bad_has_no_grant, clock, reset, rsp_valid && rsp_bad_index, rsp_granted_index == GNT_W'(SLOTS))
   `ASSERT_SAME(a_no_write_clash, clock, reset, cmd.init_write, !cmd.accept && !cmd.push)

endmodule

// ----- tb/sv/free_list_slot_allocator_unit_tb.sv -----
// Self-checking testbench for the free-list slot allocator unit.
// It predicts every reply from its own copy of the free list and link store.
// Depends on fsla_pkg and free_list_slot_allocator_unit.
`timescale 1ns / 1ps

module free_list_slot_allocator_unit_tb
   import fsla_pkg::*;
();

   localparam int SLOTS = SLOTS_DEFAULT;
   localparam int IDX_W = $clog2(SLOTS);
   localparam int GNT_W = $clog2(SLOTS + 1);
   localparam int WATCHDOG_LIMIT = 6000;
   localparam int LONG_HOLD = 300;

   typedef struct packed {
      logic [GNT_W-1:0] granted;
      logic             bad;
   } slot_reply_type;

   logic             clock;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic             req_kind = KIND_ALLOC;
   logic [IDX_W-1:0] req_slot_index = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [GNT_W-1:0] rsp_granted_index;
   logic             rsp_bad_index;

   logic [GNT_W-1:0] link_model [SLOTS];
   logic [GNT_W-1:0] head_model;
   slot_reply_type   expected_replies [$];
   logic [IDX_W-1:0] held_slots [$];

   int n_requests = 0;
   int n_granted = 0;
   int n_refused = 0;
   int n_freed = 0;
   int n_bad = 0;
   int n_replies = 0;
   int n_failures = 0;
   int tx_run_left = 0;
   int rx_stall_left = 0;
   int rx_run_left = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   bit idle_on = 1'b1;
   bit hold_request = 1'b0;

   free_list_slot_allocator_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_slot_index    (req_slot_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_granted_index (rsp_granted_index),
      .rsp_bad_index     (rsp_bad_index)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void reset_free_list();
      for (int i = 0; i < SLOTS; i++) link_model[i] = GNT_W'(i + 1);
      head_model = '0;
   endfunction

   function automatic slot_reply_type apply_request(logic kind, logic [IDX_W-1:0] idx);
      slot_reply_type r;
      r.granted = GNT_W'(SLOTS);
      r.bad = 1'b0;
      if (kind == KIND_ALLOC) begin
         if (head_model < SLOTS) begin
            r.granted = head_model;
            head_model = link_model[head_model];
         end
      end else if (int'(idx) < SLOTS) begin
         link_model[idx] = head_model;
         head_model = GNT_W'(idx);
      end else begin
         r.bad = 1'b1;
      end
      return r;
   endfunction

   task automatic send_request(input logic kind, input logic [IDX_W-1:0] idx);
      slot_reply_type r;
      int gap;
      if (idle_on && tx_run_left == 0) begin
         gap = $urandom_range(1, 18);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         tx_run_left = $urandom_range(0, 24);
      end else if (tx_run_left > 0) begin
         tx_run_left--;
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_slot_index <= idx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      r = apply_request(kind, idx);
      expected_replies.push_back(r);
      n_requests++;
      if (kind == KIND_FREE) begin
         n_freed++;
         if (r.bad) n_bad++;
      end else if (r.granted == GNT_W'(SLOTS)) begin
         n_refused++;
      end else begin
         n_granted++;
         held_slots.push_back(r.granted[IDX_W-1:0]);
      end
   endtask

   task automatic send_alloc();
      send_request(KIND_ALLOC, IDX_W'($urandom));
   endtask

   task automatic release_slot(input logic [IDX_W-1:0] s);
      for (int k = 0; k < held_slots.size(); k++) begin
         if (held_slots[k] == s) begin
            held_slots.delete(k);
            break;
         end
      end
      send_request(KIND_FREE, s);
   endtask

   task automatic free_held();
      int k;
      k = $urandom_range(0, held_slots.size() - 1);
      release_slot(held_slots[k]);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_replies.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_request(KIND_ALLOC, '0);
      send_request(KIND_ALLOC, '1);
      send_alloc();
      release_slot(IDX_W'(1));
      send_alloc();
      release_slot(IDX_W'(0));
      release_slot(IDX_W'(2));
      send_alloc();
      send_alloc();
      send_alloc();
      free_held();
      send_alloc();
   endtask

   task automatic test_exhaustion();
      while (head_model != GNT_W'(SLOTS)) send_alloc();
      repeat (3) send_alloc();
      release_slot(IDX_W'(SLOTS - 1));
      send_alloc();
      send_alloc();
      release_slot(IDX_W'(0));
      release_slot(IDX_W'(SLOTS - 1));
   endtask

   task automatic test_backpressure();
      hold_request = 1'b1;
      repeat (40) begin
         if ($urandom_range(0, 1) == 0 || held_slots.size() == 0) send_alloc();
         else free_held();
      end
      wait_drained();
   endtask

   task automatic test_unchecked_free();
      logic [IDX_W-1:0] s;
      s = held_slots[0];
      release_slot(s);
      send_request(KIND_FREE, s);
      repeat (3) send_alloc();
      if (head_model != GNT_W'(SLOTS)) send_request(KIND_FREE, head_model[IDX_W-1:0]);
      send_alloc();
   endtask

   task automatic test_random_mix(input int count, input int noise_pct);
      int roll;
      int alloc_pct;
      alloc_pct = 50;
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0) alloc_pct = $urandom_range(20, 80);
         roll = $urandom_range(0, 99);
         if (roll < noise_pct) send_request(KIND_FREE, IDX_W'($urandom));
         else if (roll < alloc_pct || held_slots.size() == 0) send_alloc();
         else free_held();
      end
   endtask

   task automatic finish_run();
      wait_drained();
      repeat (16) @(posedge clock);
      $display("Sent %0d requests: %0d grants, %0d refusals on an empty list, %0d frees.",
               n_requests, n_granted, n_refused, n_freed);
      $display("Checked %0d replies; %0d failures, %0d replies still outstanding.",
               n_replies, n_failures, expected_replies.size());
      if (n_failures == 0 && expected_replies.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   endtask

   always @(posedge clock) begin : reply_check
      slot_reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_replies++;
         if (expected_replies.size() == 0) begin
            n_failures++;
            if (n_failures <= 10)
               $display("Unexpected reply: granted %0d bad %0d",
                        rsp_granted_index, rsp_bad_index);
         end else begin
            want = expected_replies.pop_front();
            if (rsp_granted_index !== want.granted || rsp_bad_index !== want.bad) begin
               n_failures++;
               if (n_failures <= 10)
                  $display("Reply %0d mismatch: expected granted %0d bad %0d, got %0d %0d",
                           n_replies, want.granted, want.bad,
                           rsp_granted_index, rsp_bad_index);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (hold_request) begin
         hold_left = LONG_HOLD;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (!idle_on) begin
         rsp_stall <= 1'b0;
      end else if (rx_stall_left > 0) begin
         rsp_stall <= 1'b1;
         rx_stall_left--;
      end else if (rx_run_left > 0) begin
         rsp_stall <= 1'b0;
         rx_run_left--;
      end else begin
         rsp_stall <= 1'b0;
         rx_stall_left = $urandom_range(1, 18);
         rx_run_left = $urandom_range(0, 30);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("No transaction for %0d cycles; run abandoned.", quiet_cycles);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      reset_free_list();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_exhaustion();
      test_backpressure();
      test_random_mix(30, 0);
      test_unchecked_free();
      test_random_mix(30, 10);
      idle_on = 1'b0;
      test_random_mix(40, 5);
      finish_run();
   end

endmodule
